FILE: rtl/pcr_pkg.sv
`timescale 1ns / 1ps

package pcr_pkg;

   typedef enum logic [2:0] {
      ST_START   = 3'd0,
      ST_DIRECT  = 3'd1,
      ST_PROXY   = 3'd2,
      ST_RELAY   = 3'd3,
      ST_REVERSE = 3'd4,
      ST_FAILED  = 3'd5,
      ST_CONN    = 3'd6
   } conn_state_type;

   typedef enum logic [1:0] {
      NC_UNKNOWN  = 2'd0,
      NC_FORWARD  = 2'd1,
      NC_STABLE   = 2'd2,
      NC_FIREWALL = 2'd3
   } net_class_type;

   typedef enum logic [1:0] {
      ACT_WAIT   = 2'd0,
      ACT_DIRECT = 2'd1,
      ACT_PROXY  = 2'd2,
      ACT_RELAY  = 2'd3
   } action_type;

   localparam logic [1:0] PORT_NONE  = 2'd0;
   localparam logic [1:0] PORT_DHT   = 2'd1;
   localparam logic [1:0] PORT_PROXY = 2'd2;

   localparam logic [1:0] MODE_EXTERNAL = 2'd1;
   localparam logic [1:0] MODE_NAT      = 2'd2;
   localparam logic [1:0] NAT_RESTRICTED = 2'd1;
   localparam logic [1:0] NAT_FULL_CONE  = 2'd2;

   localparam logic FUNC_CONNECT = 1'b0;
   localparam logic FUNC_UPDATE  = 1'b1;
   localparam logic KIND_DIRECT  = 1'b0;

   localparam logic [2:0] UPD_CONNECTED    = 3'd1;
   localparam logic [2:0] UPD_DISCONNECTED = 3'd2;
   localparam logic [2:0] UPD_AUTH_DENIED  = 3'd3;
   localparam logic [2:0] UPD_FAILED       = 3'd4;
   localparam logic [2:0] UPD_MODE_UNAVAIL = 3'd5;

   localparam logic [2:0] CSR_FAILED_WAIT  = 3'd0;
   localparam logic [2:0] CSR_DIRECT_WAIT  = 3'd1;
   localparam logic [2:0] CSR_PROXY_WAIT   = 3'd2;
   localparam logic [2:0] CSR_RELAY_WAIT   = 3'd3;
   localparam logic [2:0] CSR_REVERSE_WAIT = 3'd4;
   localparam logic [2:0] CSR_MAX_ATTEMPTS = 3'd5;

   localparam logic [15:0] FAILED_WAIT_RST  = 16'd1800;
   localparam logic [15:0] DIRECT_WAIT_RST  = 16'd60;
   localparam logic [15:0] PROXY_WAIT_RST   = 16'd180;
   localparam logic [15:0] RELAY_WAIT_RST   = 16'd180;
   localparam logic [15:0] REVERSE_WAIT_RST = 16'd300;
   localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;

   localparam logic [3:0] COUNT_FULL = 4'hF;

   typedef struct packed {
      logic        func;
      logic        connect_kind;
      logic [1:0]  net_mode;
      logic [1:0]  nat_kind;
      logic [2:0]  update_code;
      logic [31:0] now_secs;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] port_choice;
      logic       update_ok;
      logic [2:0] state_now;
   } rsp_type;

endpackage

FILE: rtl/peer_connect_retry_fsm.sv
`timescale 1ns / 1ps

// Per-peer connection retry controller.
// req channel: one request per accepted req_valid/!req_stall, either a connect
// request (func 0) or an update event (func 1). rsp channel: exactly one
// result per request, in order, on rsp_valid/!rsp_stall.
// csr channel: register writes by index (0 failed wait, 1 direct wait,
// 2 proxy wait, 3 relay wait, 4 reverse wait, 5 max attempts); csr_ready is
// always high and writes take effect on the next request.
// The request is decoded against the held state, the wait interval check and
// the state update happen in the accepting cycle and the result lands in the
// output register. One request per cycle is sustained while the receiver does
// not stall; the output register is the only buffer.
// When the receiver stalls with a result held, req_stall is raised and the
// held result and state stay put until the result is taken; a request is
// still taken in the same cycle the held result leaves.
// Synchronous reset returns the machine to start, network class unknown,
// attempt time and count zero, all intervals to their defaults, and empties
// the output register.
module peer_connect_retry_fsm (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  pcr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output pcr_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_wdata
);
   import pcr_pkg::*;

   logic [15:0] failed_wait_ff, direct_wait_ff, proxy_wait_ff;
   logic [15:0] relay_wait_ff, reverse_wait_ff;
   logic [3:0]  max_attempts_ff;

   conn_state_type conn_state_ff, conn_state_in;
   net_class_type  net_class_ff, net_class_in;
   logic [31:0]    attempt_time_ff, attempt_time_in;
   logic [3:0]     attempt_count_ff, attempt_count_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    req_accept;

   logic [31:0] elapsed;
   logic [15:0] wait_sel;
   logic        too_soon;
   logic        count_over;
   logic [1:0]  pmode;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_wait_ff  <= FAILED_WAIT_RST;
         direct_wait_ff  <= DIRECT_WAIT_RST;
         proxy_wait_ff   <= PROXY_WAIT_RST;
         relay_wait_ff   <= RELAY_WAIT_RST;
         reverse_wait_ff <= REVERSE_WAIT_RST;
         max_attempts_ff <= MAX_ATTEMPTS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FAILED_WAIT:  failed_wait_ff  <= csr_wdata;
            CSR_DIRECT_WAIT:  direct_wait_ff  <= csr_wdata;
            CSR_PROXY_WAIT:   proxy_wait_ff   <= csr_wdata;
            CSR_RELAY_WAIT:   relay_wait_ff   <= csr_wdata;
            CSR_REVERSE_WAIT: reverse_wait_ff <= csr_wdata;
            CSR_MAX_ATTEMPTS: max_attempts_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_state_ff    <= ST_START;
         net_class_ff     <= NC_UNKNOWN;
         attempt_time_ff  <= '0;
         attempt_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            conn_state_ff    <= conn_state_in;
            net_class_ff     <= net_class_in;
            attempt_time_ff  <= attempt_time_in;
            attempt_count_ff <= attempt_count_in;
            rsp_valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // one interval compare, the interval picked by state and request kind
   always_comb begin
      wait_sel = failed_wait_ff;
      if (req_data.connect_kind == KIND_DIRECT) begin
         if (conn_state_ff == ST_DIRECT) wait_sel = direct_wait_ff;
      end else begin
         unique case (conn_state_ff)
            ST_PROXY:   wait_sel = proxy_wait_ff;
            ST_RELAY:   wait_sel = relay_wait_ff;
            ST_REVERSE: wait_sel = reverse_wait_ff;
            default:    wait_sel = failed_wait_ff;
         endcase
      end
   end

   assign elapsed    = req_data.now_secs - attempt_time_ff;
   assign too_soon   = elapsed[31] | (elapsed < {16'd0, wait_sel});
   assign count_over = attempt_count_ff > max_attempts_ff;

   always_comb begin
      conn_state_type start_st;
      logic           go_begin;
      logic           go_retry;
      logic           fresh;

      start_st      = conn_state_ff;
      go_begin      = 1'b0;
      go_retry      = 1'b0;
      fresh         = 1'b0;
      conn_state_in = conn_state_ff;
      net_class_in  = net_class_ff;
      rsp_in        = '0;
      rsp_in.action      = ACT_WAIT;
      rsp_in.port_choice = PORT_NONE;

      if (req_data.net_mode == MODE_EXTERNAL) begin
         net_class_in = NC_FORWARD;
      end else if (req_data.net_mode == MODE_NAT) begin
         net_class_in = (req_data.nat_kind == NAT_RESTRICTED ||
                         req_data.nat_kind == NAT_FULL_CONE) ? NC_STABLE : NC_FIREWALL;
      end else begin
         net_class_in = NC_UNKNOWN;
      end
      pmode = (net_class_in == NC_FORWARD) ? PORT_DHT : PORT_PROXY;

      if (req_data.func == FUNC_CONNECT) begin
         if (req_data.connect_kind == KIND_DIRECT) begin
            unique case (conn_state_ff)
               ST_CONN: ;
               ST_DIRECT: begin
                  if (!too_soon) begin
                     if (count_over) begin
                        go_begin = 1'b1;
                        start_st = ST_FAILED;
                     end else begin
                        go_retry = 1'b1;
                        rsp_in.action      = ACT_DIRECT;
                        rsp_in.port_choice = PORT_DHT;
                     end
                  end
               end
               ST_FAILED: fresh = !too_soon;
               default:   fresh = 1'b1;
            endcase
            if (fresh) begin
               go_begin = 1'b1;
               start_st = ST_DIRECT;
               rsp_in.action      = ACT_DIRECT;
               rsp_in.port_choice = PORT_DHT;
            end
         end else begin
            unique case (conn_state_ff)
               ST_CONN: ;
               ST_PROXY: begin
                  if (!too_soon) begin
                     if (count_over) begin
                        go_begin = 1'b1;
                        start_st = ST_RELAY;
                        rsp_in.action      = ACT_RELAY;
                        rsp_in.port_choice = PORT_DHT;
                     end else begin
                        go_retry = 1'b1;
                        rsp_in.action      = ACT_PROXY;
                        rsp_in.port_choice = pmode;
                     end
                  end
               end
               ST_REVERSE: begin
                  if (!too_soon) begin
                     go_begin = 1'b1;
                     start_st = ST_RELAY;
                     rsp_in.action      = ACT_RELAY;
                     rsp_in.port_choice = PORT_DHT;
                  end
               end
               ST_RELAY: begin
                  if (!too_soon) begin
                     if (count_over) begin
                        go_begin = 1'b1;
                        start_st = ST_FAILED;
                     end else begin
                        go_retry = 1'b1;
                        rsp_in.action      = ACT_RELAY;
                        rsp_in.port_choice = PORT_DHT;
                     end
                  end
               end
               ST_FAILED: fresh = !too_soon;
               default:   fresh = 1'b1;
            endcase
            if (fresh) begin
               go_begin = 1'b1;
               if (net_class_in != NC_FIREWALL) begin
                  start_st = ST_PROXY;
                  rsp_in.action      = ACT_PROXY;
                  rsp_in.port_choice = pmode;
               end else begin
                  start_st = ST_RELAY;
                  rsp_in.action      = ACT_RELAY;
                  rsp_in.port_choice = PORT_DHT;
               end
            end
         end
         if (go_begin) conn_state_in = start_st;
      end else begin
         // update event: network class untouched
         net_class_in = net_class_ff;
         priority if (req_data.update_code == UPD_CONNECTED) begin
            conn_state_in = ST_CONN;
         end else if (req_data.update_code == UPD_DISCONNECTED) begin
            if (conn_state_ff == ST_CONN) begin
               conn_state_in    = ST_START;
               rsp_in.update_ok = 1'b1;
            end
         end else if (conn_state_ff == ST_DIRECT || conn_state_ff == ST_PROXY ||
                      conn_state_ff == ST_RELAY) begin
            unique case (req_data.update_code)
               UPD_AUTH_DENIED: begin
                  conn_state_in    = ST_FAILED;
                  rsp_in.update_ok = 1'b1;
               end
               UPD_FAILED: rsp_in.update_ok = 1'b1;
               UPD_MODE_UNAVAIL: begin
                  if (conn_state_ff == ST_PROXY) begin
                     conn_state_in = (net_class_ff == NC_FORWARD) ? ST_REVERSE : ST_RELAY;
                     rsp_in.update_ok = 1'b1;
                  end else begin
                     conn_state_in    = ST_FAILED;
                     rsp_in.update_ok = (conn_state_ff == ST_DIRECT);
                  end
               end
               default: ;
            endcase
         end else begin
            rsp_in.update_ok = 1'b0;
         end
      end

      attempt_time_in  = attempt_time_ff;
      attempt_count_in = attempt_count_ff;
      if (go_begin) begin
         attempt_time_in  = req_data.now_secs;
         attempt_count_in = '0;
      end else if (go_retry) begin
         attempt_time_in = req_data.now_secs;
         if (attempt_count_ff != COUNT_FULL) attempt_count_in = attempt_count_ff + 4'd1;
      end

      rsp_in.state_now = conn_state_in;
   end

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request gave no result");

   a_state_echo: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_ff.state_now == conn_state_ff)
      else $error("reported state differs from held state");

   a_update_no_action: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.func == FUNC_UPDATE |=>
         rsp_ff.action == ACT_WAIT && rsp_ff.port_choice == PORT_NONE)
      else $error("update event produced a connect action");

   a_wait_no_port: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.action == ACT_WAIT |-> rsp_ff.port_choice == PORT_NONE)
      else $error("port chosen while waiting");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(attempt_count_ff) && $stable(attempt_time_ff))
      else $error("attempt record changed without a request");

endmodule
